### sv/rsn_pkg.sv
package rsn_pkg;

  // coordinate and intermediate widths
  localparam int CRD_W   = 32;
  localparam int RAD_W   = CRD_W - 1;
  localparam int OFS_W   = CRD_W + 1;      // origin minus center
  localparam int A_W     = 2 * CRD_W;      // d.d, unsigned
  localparam int H_W     = 2 * CRD_W + 2;  // d.w, signed
  localparam int C_W     = 2 * CRD_W + 3;  // w.w - r*r, signed
  localparam int E_W     = 4 * CRD_W + 4;  // quarter discriminant, signed
  localparam int S_W     = 2 * CRD_W + 2;  // integer square root
  localparam int SR_W    = S_W + 2;        // square root partial remainder
  localparam int N_W     = 2 * CRD_W + 4;  // -(h + sqrt(e)), signed
  localparam int P_W     = N_W + CRD_W;    // numerator times direction, signed
  localparam int Q_W     = P_W - 1;        // quotient magnitude
  localparam int MUL_LAT = 3;              // multiplier pipeline depth

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_ZERO_DIR = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [CRD_W-1:0] origin_x;
    logic signed [CRD_W-1:0] origin_y;
    logic signed [CRD_W-1:0] origin_z;
    logic signed [CRD_W-1:0] dir_x;
    logic signed [CRD_W-1:0] dir_y;
    logic signed [CRD_W-1:0] dir_z;
    logic signed [CRD_W-1:0] center_x;
    logic signed [CRD_W-1:0] center_y;
    logic signed [CRD_W-1:0] center_z;
    logic [RAD_W-1:0]        radius;
  } req_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] hit_x;
    logic signed [CRD_W-1:0] hit_y;
    logic signed [CRD_W-1:0] hit_z;
    status_e                 status;
  } res_t;

  // values that ride along the pipeline next to the arithmetic
  typedef struct packed {
    logic [2:0][CRD_W-1:0] org;
    logic [2:0][CRD_W-1:0] dir;
    logic [A_W-1:0]        a;
    logic [H_W-1:0]        h;
    logic                  zero;
    logic                  miss;
  } side_t;

  typedef struct packed {
    logic [SR_W-1:0] rem;
    logic [S_W-1:0]  root;
    logic [E_W-1:0]  rad;
  } sqrt_t;

  // one divide lane: dividend shifts out the top while quotient bits shift in
  typedef struct packed {
    logic           neg;
    logic [Q_W-1:0] nq;
    logic [A_W-1:0] rem;
  } lane_t;

  typedef lane_t [2:0] lanes_t;

endpackage

### sv/rsn_mul.sv
module rsn_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int PW = AW + BW;
  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;

  logic [AW-1:0]      a_mag;
  logic [BW-1:0]      b_mag;
  logic [AH+BH-1:0]   hh_q;
  logic [AH+BL-1:0]   hl_q;
  logic [AL+BH-1:0]   lh_q;
  logic [AL+BL-1:0]   ll_q;
  logic               neg1_q;
  logic               neg2_q;
  logic [PW-1:0]      sum_q;
  logic [PW-1:0]      p_q;

  // magnitudes of the signed operands
  always_comb begin
    a_mag = a_i[AW-1] ? (~a_i + AW'(1)) : a_i;
    b_mag = b_i[BW-1] ? (~b_i + BW'(1)) : b_i;
  end

  // partial products, then their sum, then the sign
  always_ff @(posedge clk_i) begin
    hh_q   <= a_mag[AW-1:AL] * b_mag[BW-1:BL];
    hl_q   <= a_mag[AW-1:AL] * b_mag[BL-1:0];
    lh_q   <= a_mag[AL-1:0] * b_mag[BW-1:BL];
    ll_q   <= a_mag[AL-1:0] * b_mag[BL-1:0];
    neg1_q <= a_i[AW-1] ^ b_i[BW-1];
    sum_q  <= (PW'(hh_q) << (AL + BL)) + (PW'(hl_q) << AL)
            + (PW'(lh_q) << BL) + PW'(ll_q);
    neg2_q <= neg1_q;
    p_q    <= neg2_q ? (~sum_q + PW'(1)) : sum_q;
  end

  assign p_o = p_q;

endmodule

### sv/rsn_sqrt_cell.sv
module rsn_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  rsn_pkg::side_t side_i,
  input  rsn_pkg::sqrt_t sq_i,
  output logic          valid_o,
  output rsn_pkg::side_t side_o,
  output rsn_pkg::sqrt_t sq_o
);

  import rsn_pkg::*;

  logic [SR_W-1:0] rs;
  logic [SR_W-1:0] trial;
  logic            ge;
  sqrt_t           sq_d;
  logic            valid_q;
  side_t           side_q;
  sqrt_t           sq_q;

  // one root bit: bring down two radicand bits and try 4*root+1
  always_comb begin
    rs        = {sq_i.rem[SR_W-3:0], sq_i.rad[E_W-1 -: 2]};
    trial     = {sq_i.root, 2'b01};
    ge        = (rs >= trial);
    sq_d.rem  = ge ? (rs - trial) : rs;
    sq_d.root = {sq_i.root[S_W-2:0], ge};
    sq_d.rad  = {sq_i.rad[E_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    sq_q   <= sq_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign sq_o    = sq_q;

endmodule

### sv/rsn_div_cell.sv
module rsn_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  rsn_pkg::side_t  side_i,
  input  rsn_pkg::lanes_t ln_i,
  output logic            valid_o,
  output rsn_pkg::side_t  side_o,
  output rsn_pkg::lanes_t ln_o
);

  import rsn_pkg::*;

  logic [2:0][A_W:0] rs;
  logic [2:0][A_W:0] diff;
  logic [2:0]        ge;
  lanes_t            ln_d;
  logic              valid_q;
  side_t             side_q;
  lanes_t            ln_q;

  // one quotient bit per lane, all three lanes share the divisor a
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rs[k]          = {ln_i[k].rem, ln_i[k].nq[Q_W-1]};
      diff[k]        = rs[k] - {1'b0, side_i.a};
      ge[k]          = (rs[k] >= {1'b0, side_i.a});
      ln_d[k].neg    = ln_i[k].neg;
      ln_d[k].nq     = {ln_i[k].nq[Q_W-2:0], ge[k]};
      ln_d[k].rem    = ge[k] ? diff[k][A_W-1:0] : rs[k][A_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    ln_q   <= ln_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign ln_o    = ln_q;

endmodule

### sv/ray_sphere_nearest_hit.sv
// channel   ports                  direction  transfer when
// request   start, busy, req_i     in         start high and busy low at clk_i rise
// result    valid_o, res_o         out        valid_o high, one cycle per result
//
// one request is taken every cycle; each result passes through the square root cell chain
// (66 cells, one root bit each), the divide cell chain (99 cells, one quotient bit each),
// three 3-stage multiplier groups and six plain pipeline registers.
// busy is held low: nothing stalls, and the receiver cannot hold results off.
// rst_ni clears the valid bits of every stage; data registers are not reset.
module ray_sphere_nearest_hit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rsn_pkg::req_t req_i,
  output logic          valid_o,
  output rsn_pkg::res_t res_o
);

  import rsn_pkg::*;

  localparam int T_W     = Q_W + 2;
  localparam int TOT_LAT = 3 * MUL_LAT + S_W + Q_W + 6;

  logic                   acc;
  logic [2:0][CRD_W-1:0]  org_in;
  logic [2:0][CRD_W-1:0]  dir_in;
  logic [2:0][CRD_W-1:0]  ctr_in;
  logic [2:0][OFS_W-1:0]  ofs;

  // stage 1
  logic                   v1_q;
  side_t                  side1_q;
  logic [2:0][OFS_W-1:0]  w1_q;
  logic [RAD_W-1:0]       rad1_q;

  // product group a
  logic [2:0][2*CRD_W-1:0] dd;
  logic [2:0][2*CRD_W:0]   dw;
  logic [2:0][2*CRD_W+1:0] ww;
  logic [2*CRD_W-1:0]      rr;
  logic [MUL_LAT-1:0]      vla_q;
  side_t                   dla_q [MUL_LAT];

  // stage 2
  logic [A_W-1:0]         a_sum;
  logic [H_W-1:0]         h_sum;
  logic [C_W-1:0]         c_sum;
  side_t                  side2_d;
  logic                   v2_q;
  side_t                  side2_q;
  logic [C_W-1:0]         c2_q;

  // product group b
  logic [E_W-1:0]         hh;
  logic [E_W-1:0]         ac;
  logic [MUL_LAT-1:0]     vlb_q;
  side_t                  dlb_q [MUL_LAT];

  // stage 3 and square root chain
  logic [E_W-1:0]         e_val;
  side_t                  side3_d;
  sqrt_t                  sq3_d;
  logic                   sv   [S_W+1];
  side_t                  sside [S_W+1];
  sqrt_t                  sq   [S_W+1];

  // stage 4
  logic [N_W-1:0]         hs;
  logic                   v4_q;
  side_t                  side4_q;
  logic [N_W-1:0]         num4_q;

  // product group c
  logic [2:0][P_W-1:0]    pd;
  logic [MUL_LAT-1:0]     vlc_q;
  side_t                  dlc_q [MUL_LAT];

  // stage 5 and divide chain
  lanes_t                 ln5_d;
  logic [2:0][P_W-1:0]    pmag;
  logic                   dv   [Q_W+1];
  side_t                  dside [Q_W+1];
  lanes_t                 dln  [Q_W+1];

  // output stage
  logic [2:0][T_W-1:0]    opnd;
  logic [2:0][T_W-1:0]    pt;
  logic [2:0]             ovf;
  logic [2:0][CRD_W-1:0]  crd;
  res_t                   res_d;
  logic                   valid_q;
  res_t                   res_q;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // unpack the request and form w = origin - center
  always_comb begin
    org_in = {req_i.origin_z, req_i.origin_y, req_i.origin_x};
    dir_in = {req_i.dir_z, req_i.dir_y, req_i.dir_x};
    ctr_in = {req_i.center_z, req_i.center_y, req_i.center_x};
    for (int k = 0; k < 3; k++) begin
      ofs[k] = OFS_W'($signed(org_in[k])) - OFS_W'($signed(ctr_in[k]));
    end
  end

  // valid bits of the plain stages and delay lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      vla_q   <= '0;
      v2_q    <= 1'b0;
      vlb_q   <= '0;
      sv[0]   <= 1'b0;
      v4_q    <= 1'b0;
      vlc_q   <= '0;
      dv[0]   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      v1_q    <= acc;
      vla_q   <= {vla_q[MUL_LAT-2:0], v1_q};
      v2_q    <= vla_q[MUL_LAT-1];
      vlb_q   <= {vlb_q[MUL_LAT-2:0], v2_q};
      sv[0]   <= vlb_q[MUL_LAT-1];
      v4_q    <= sv[S_W];
      vlc_q   <= {vlc_q[MUL_LAT-2:0], v4_q};
      dv[0]   <= vlc_q[MUL_LAT-1];
      valid_q <= dv[Q_W];
    end
  end

  // stage 1 capture
  always_ff @(posedge clk_i) begin
    side1_q.org  <= org_in;
    side1_q.dir  <= dir_in;
    side1_q.a    <= '0;
    side1_q.h    <= '0;
    side1_q.zero <= 1'b0;
    side1_q.miss <= 1'b0;
    w1_q         <= ofs;
    rad1_q       <= req_i.radius;
  end

  // products d.d, d.w, w.w and r*r
  for (genvar k = 0; k < 3; k++) begin : g_mul_a
    rsn_mul #(.AW(CRD_W), .BW(CRD_W)) u_dd (
      .clk_i(clk_i), .a_i(side1_q.dir[k]), .b_i(side1_q.dir[k]), .p_o(dd[k])
    );
    rsn_mul #(.AW(CRD_W), .BW(OFS_W)) u_dw (
      .clk_i(clk_i), .a_i(side1_q.dir[k]), .b_i(w1_q[k]), .p_o(dw[k])
    );
    rsn_mul #(.AW(OFS_W), .BW(OFS_W)) u_ww (
      .clk_i(clk_i), .a_i(w1_q[k]), .b_i(w1_q[k]), .p_o(ww[k])
    );
  end

  rsn_mul #(.AW(CRD_W), .BW(CRD_W)) u_rr (
    .clk_i(clk_i), .a_i({1'b0, rad1_q}), .b_i({1'b0, rad1_q}), .p_o(rr)
  );

  // side data follows the multipliers
  always_ff @(posedge clk_i) begin
    dla_q[0] <= side1_q;
    dlb_q[0] <= side2_q;
    dlc_q[0] <= side4_q;
    for (int i = 1; i < MUL_LAT; i++) begin
      dla_q[i] <= dla_q[i-1];
      dlb_q[i] <= dlb_q[i-1];
      dlc_q[i] <= dlc_q[i-1];
    end
  end

  // stage 2: a, h and c
  always_comb begin
    a_sum = A_W'(dd[0]) + A_W'(dd[1]) + A_W'(dd[2]);
    h_sum = H_W'($signed(dw[0])) + H_W'($signed(dw[1])) + H_W'($signed(dw[2]));
    c_sum = C_W'($signed(ww[0])) + C_W'($signed(ww[1])) + C_W'($signed(ww[2]))
          - C_W'($signed(rr));
    side2_d   = dla_q[MUL_LAT-1];
    side2_d.a = a_sum;
    side2_d.h = h_sum;
  end

  always_ff @(posedge clk_i) begin
    side2_q <= side2_d;
    c2_q    <= c_sum;
  end

  // products h*h and a*c
  rsn_mul #(.AW(H_W), .BW(H_W)) u_hh (
    .clk_i(clk_i), .a_i(side2_q.h), .b_i(side2_q.h), .p_o(hh)
  );

  rsn_mul #(.AW(A_W + 1), .BW(C_W)) u_ac (
    .clk_i(clk_i), .a_i({1'b0, side2_q.a}), .b_i(c2_q), .p_o(ac)
  );

  // stage 3: discriminant, miss and zero direction flags
  always_comb begin
    e_val        = hh - ac;
    side3_d      = dlb_q[MUL_LAT-1];
    side3_d.zero = (side3_d.a == '0);
    side3_d.miss = e_val[E_W-1];
    sq3_d.rem    = '0;
    sq3_d.root   = '0;
    sq3_d.rad    = (side3_d.zero || side3_d.miss) ? '0 : e_val;
  end

  always_ff @(posedge clk_i) begin
    sside[0] <= side3_d;
    sq[0]    <= sq3_d;
  end

  // square root cell chain
  for (genvar i = 0; i < S_W; i++) begin : g_sqrt
    rsn_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sv[i]),
      .side_i  (sside[i]),
      .sq_i    (sq[i]),
      .valid_o (sv[i+1]),
      .side_o  (sside[i+1]),
      .sq_o    (sq[i+1])
    );
  end

  // stage 4: numerator -(h + sqrt(e))
  assign hs = N_W'($signed(sside[S_W].h)) + N_W'(sq[S_W].root);

  always_ff @(posedge clk_i) begin
    side4_q <= sside[S_W];
    num4_q  <= ~hs + N_W'(1);
  end

  // numerator times each direction component
  for (genvar k = 0; k < 3; k++) begin : g_mul_c
    rsn_mul #(.AW(N_W), .BW(CRD_W)) u_nd (
      .clk_i(clk_i), .a_i(num4_q), .b_i(side4_q.dir[k]), .p_o(pd[k])
    );
  end

  // stage 5: sign and magnitude into the divide lanes
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pmag[k]      = pd[k][P_W-1] ? (~pd[k] + P_W'(1)) : pd[k];
      ln5_d[k].neg = pd[k][P_W-1];
      ln5_d[k].nq  = pmag[k][Q_W-1:0];
      ln5_d[k].rem = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    dside[0] <= dlc_q[MUL_LAT-1];
    dln[0]   <= ln5_d;
  end

  // divide cell chain
  for (genvar i = 0; i < Q_W; i++) begin : g_div
    rsn_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[i]),
      .side_i  (dside[i]),
      .ln_i    (dln[i]),
      .valid_o (dv[i+1]),
      .side_o  (dside[i+1]),
      .ln_o    (dln[i+1])
    );
  end

  // floor the quotient, add the origin, saturate and pick the status
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      opnd[k] = dln[Q_W][k].neg ? ~T_W'(dln[Q_W][k].nq) : T_W'(dln[Q_W][k].nq);
      pt[k]   = T_W'($signed(dside[Q_W].org[k])) + opnd[k]
              + T_W'(dln[Q_W][k].neg && (dln[Q_W][k].rem == '0));
      ovf[k]  = !((&pt[k][T_W-1:CRD_W-1]) || !(|pt[k][T_W-1:CRD_W-1]));
      if (ovf[k]) begin
        crd[k] = pt[k][T_W-1] ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
      end else begin
        crd[k] = pt[k][CRD_W-1:0];
      end
    end
    if (dside[Q_W].zero) begin
      res_d.hit_x  = '0;
      res_d.hit_y  = '0;
      res_d.hit_z  = '0;
      res_d.status = ST_ZERO_DIR;
    end else if (dside[Q_W].miss) begin
      res_d.hit_x  = '0;
      res_d.hit_y  = '0;
      res_d.hit_z  = '0;
      res_d.status = ST_MISS;
    end else begin
      res_d.hit_x  = crd[0];
      res_d.hit_y  = crd[1];
      res_d.hit_z  = crd[2];
      res_d.status = (|ovf) ? ST_SAT : ST_HIT;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  // each accepted request yields exactly one result after the fixed latency
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(acc, TOT_LAT))
    else $error("result without a matching request");

  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##TOT_LAT valid_o)
    else $error("request produced no result");

  // miss and zero direction give a zero point
  a_zero_pt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (res_o.status == ST_MISS || res_o.status == ST_ZERO_DIR))
      |-> (res_o.hit_x == '0 && res_o.hit_y == '0 && res_o.hit_z == '0))
    else $error("non-hit status with nonzero point");

  // a saturated result has at least one coordinate at a limit
  a_sat_lim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.status == ST_SAT)
      |-> ((res_o.hit_x == {1'b0, {(CRD_W-1){1'b1}}})
        || (res_o.hit_x == {1'b1, {(CRD_W-1){1'b0}}})
        || (res_o.hit_y == {1'b0, {(CRD_W-1){1'b1}}})
        || (res_o.hit_y == {1'b1, {(CRD_W-1){1'b0}}})
        || (res_o.hit_z == {1'b0, {(CRD_W-1){1'b1}}})
        || (res_o.hit_z == {1'b1, {(CRD_W-1){1'b0}}})))
    else $error("saturation status without a clipped coordinate");

endmodule
